// ===== hdl/cdq_pkg.sv =====
// Shared types and constants for the circular deque.
package cdq_pkg;

  localparam int MAX_DEPTH = 16;
  localparam int PTR_W     = $clog2(MAX_DEPTH);
  localparam int CNT_W     = 5;
  localparam int DATA_W    = 32;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] data_value;
  } cmd_t;

  typedef struct packed {
    logic                     accepted;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } rsp_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_cmd;
    logic exec;
    logic load_rsp;
  } ctrl_t;

endpackage

// ===== hdl/cdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cdq_ctrl.sv =====
// Sequencer for the circular deque: steps each command through update, read and result load.
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_stall,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  output ctrl_t ctrl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_free;

  assign rsp_free      = !rsp_valid || !rsp_stall;
  assign cmd_stall     = (state != S_IDLE);
  assign ctrl.load_cmd = (state == S_IDLE) && cmd_valid;
  assign ctrl.exec     = (state == S_EXEC);
  assign ctrl.load_rsp = (state == S_LOAD) && rsp_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_READ;
      S_READ: state_next = S_LOAD;
      S_LOAD: if (rsp_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/cdq_dpath.sv =====
// Datapath of the circular deque: pointers, count, capacity, ring memory and result register.
module cdq_dpath
  import cdq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  ctrl_t            ctrl,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output logic [CNT_W-1:0] capacity,
  output rsp_t             rsp
);

  cmd_t              cmd_q;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  tail_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              ok;
  logic              ok_q;
  logic              full;
  logic              empty;
  logic [CNT_W-1:0]  cap_clamped;
  logic [PTR_W-1:0]  cap_m1;
  logic [CNT_W-1:0]  head_inc;
  logic [CNT_W-1:0]  tail_inc;
  logic [PTR_W-1:0]  head_up;
  logic [PTR_W-1:0]  head_down;
  logic [PTR_W-1:0]  tail_up;
  logic [PTR_W-1:0]  tail_down;
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] front_rd;
  logic [DATA_W-1:0] rear_rd;

  always_comb begin
    cap_clamped = cfg_wdata;
    if (cfg_wdata == '0) begin
      cap_clamped = CNT_W'(1);
    end else if (cfg_wdata > CNT_W'(MAX_DEPTH)) begin
      cap_clamped = CNT_W'(MAX_DEPTH);
    end
  end

  assign cap_m1    = PTR_W'(capacity - CNT_W'(1));
  assign head_inc  = CNT_W'(head) + CNT_W'(1);
  assign tail_inc  = CNT_W'(tail) + CNT_W'(1);
  assign head_up   = (head_inc >= capacity) ? '0 : head_inc[PTR_W-1:0];
  assign tail_up   = (tail_inc >= capacity) ? '0 : tail_inc[PTR_W-1:0];
  assign head_down = (head == '0) ? cap_m1 : head - PTR_W'(1);
  assign tail_down = (tail == '0) ? cap_m1 : tail - PTR_W'(1);

  assign full  = (count >= capacity);
  assign empty = (count == '0);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ok         = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = head_down;
    unique case (cmd_q.operation)
      OP_PUSH_FRONT: begin
        ok        = !full;
        ram_waddr = head_down;
        if (!full) begin
          head_next  = head_down;
          count_next = count + CNT_W'(1);
          ram_we     = ctrl.exec;
        end
      end
      OP_PUSH_BACK: begin
        ok        = !full;
        ram_waddr = tail_up;
        if (!full) begin
          tail_next  = tail_up;
          count_next = count + CNT_W'(1);
          ram_we     = ctrl.exec;
        end
      end
      OP_POP_FRONT: begin
        ok = !empty;
        if (!empty) begin
          head_next  = head_up;
          count_next = count - CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        ok = !empty;
        if (!empty) begin
          tail_next  = tail_down;
          count_next = count - CNT_W'(1);
        end
      end
      default: ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(MAX_DEPTH);
      head     <= '0;
      tail     <= PTR_W'(MAX_DEPTH - 1);
      count    <= '0;
    end else if (cfg_we) begin
      capacity <= cap_clamped;
      head     <= '0;
      tail     <= PTR_W'(cap_clamped - CNT_W'(1));
      count    <= '0;
    end else if (ctrl.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_cmd) begin
      cmd_q <= cmd;
    end
    if (ctrl.exec) begin
      ok_q <= ok;
    end
    if (ctrl.load_rsp) begin
      rsp.accepted    <= ok_q;
      rsp.front_value <= empty ? '1 : front_rd;
      rsp.rear_value  <= empty ? '1 : rear_rd;
      rsp.is_empty    <= empty;
      rsp.is_full     <= full;
    end
  end

  // Two copies of the ring, written together, so front and rear read in the same cycle.
  cdq_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DEPTH)) u_front_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd_q.data_value),
    .raddr (head),
    .rdata (front_rd)
  );

  cdq_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DEPTH)) u_rear_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd_q.data_value),
    .raddr (tail),
    .rdata (rear_rd)
  );

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk) disable iff (rst) count <= capacity)
    else $error("entry count exceeds capacity");
  a_head_in_range: assert property (@(posedge clk) disable iff (rst) CNT_W'(head) < capacity)
    else $error("head pointer outside capacity");
  a_tail_in_range: assert property (@(posedge clk) disable iff (rst) CNT_W'(tail) < capacity)
    else $error("tail pointer outside capacity");
  a_write_only_when_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (count == $past(count) + CNT_W'(1)))
    else $error("ring write without a count increment");
`endif

endmodule

// ===== hdl/circular_deque.sv =====
// Circular deque top level: a double-ended queue of signed 32-bit values in a ring memory.
// Each command transfer steps through accept, pointer update and ring write, ring read
// (set by the registered read of the ring memory) and result load. The result
// register lets the next command be accepted while a result transfer is still stalled.
// Writing the capacity register (1 to 16, other values clamped) empties the deque.
module circular_deque
  import cdq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmd_t              cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  ctrl_t                ctrl;
  logic                 cfg_we;
  logic [CNT_W-1:0]     capacity;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_we  = psel && penable && pwrite && pready && (reg_idx == REG_CAPACITY);
  assign prdata  = (reg_idx == REG_CAPACITY) ? APB_DW'(capacity) : '0;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctrl      (ctrl)
  );

  cdq_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctrl      (ctrl),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[CNT_W-1:0]),
    .capacity  (capacity),
    .rsp       (rsp)
  );

endmodule

// ===== verif/deque_checker.sv =====
// Checker for the circular deque: predicts every result and compares it with the block's output.
`timescale 1ns / 100ps

module deque_checker
  import cdq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_stall,
  input  cmd_t              cmd,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                refused
);

  logic signed [DATA_W-1:0] ring [MAX_DEPTH];
  logic [PTR_W-1:0]         head_ptr;
  logic [PTR_W-1:0]         tail_ptr;
  logic [CNT_W-1:0]         fill;
  logic [CNT_W-1:0]         cap;
  rsp_t                     results_due [$];

  function automatic logic [CNT_W-1:0] fit_capacity(logic [CNT_W-1:0] raw);
    if (raw == '0) begin
      return CNT_W'(1);
    end
    if (raw > CNT_W'(MAX_DEPTH)) begin
      return CNT_W'(MAX_DEPTH);
    end
    return raw;
  endfunction

  function automatic void clear_deque();
    head_ptr = '0;
    tail_ptr = PTR_W'(cap - 1'b1);
    fill     = '0;
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return ({1'b0, p} + 1'b1 >= cap) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(cap - 1'b1) : p - 1'b1;
  endfunction

  // Applies one operation to the model deque and returns the state seen after it.
  function automatic rsp_t apply_deque_op(cmd_t c);
    rsp_t r;
    logic ok;
    ok = 1'b0;
    case (c.operation)
      OP_PUSH_FRONT: begin
        if (fill < cap) begin
          head_ptr       = ring_prev(head_ptr);
          ring[head_ptr] = c.data_value;
          fill           = fill + 1'b1;
          ok             = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (fill < cap) begin
          tail_ptr       = ring_next(tail_ptr);
          ring[tail_ptr] = c.data_value;
          fill           = fill + 1'b1;
          ok             = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (fill != '0) begin
          head_ptr = ring_next(head_ptr);
          fill     = fill - 1'b1;
          ok       = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (fill != '0) begin
          tail_ptr = ring_prev(tail_ptr);
          fill     = fill - 1'b1;
          ok       = 1'b1;
        end
      end
    endcase
    r.accepted    = ok;
    r.is_empty    = (fill == '0);
    r.is_full     = (fill >= cap);
    r.front_value = r.is_empty ? '1 : ring[head_ptr];
    r.rear_value  = r.is_empty ? '1 : ring[tail_ptr];
    return r;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: mismatch on %s in result %0d: expected %h, got %h",
                 $time, name, checked, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
        ring[i] = '0;
      end
      cap = CNT_W'(MAX_DEPTH);
      clear_deque();
      results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_CAPACITY) begin
        cap = fit_capacity(pwdata[CNT_W-1:0]);
        clear_deque();
      end
      // The result register sits behind the ring read, so a result never belongs
      // to a command accepted at the same edge.
      if (rsp_valid && !rsp_stall) begin
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result transfer with no result outstanding", $time);
          end
        end else begin
          want = results_due.pop_front();
          check_field("accepted", DATA_W'(want.accepted), DATA_W'(rsp.accepted));
          check_field("front_value", want.front_value, rsp.front_value);
          check_field("rear_value", want.rear_value, rsp.rear_value);
          check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(rsp.is_empty));
          check_field("is_full", DATA_W'(want.is_full), DATA_W'(rsp.is_full));
          checked++;
        end
      end
      if (cmd_valid && !cmd_stall) begin
        want = apply_deque_op(cmd);
        if (!want.accepted) begin
          refused++;
        end
        results_due.push_back(want);
      end
    end
    pending = results_due.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the circular deque: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb;
  import cdq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 100;
  localparam int N_PHASES    = 12;
  localparam logic [APB_AW-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
  localparam logic [APB_AW-1:0] SPARE_ADDR = {~REG_CAPACITY, 2'b00};

  logic              clk;
  logic              rst;
  logic              cmd_valid;
  logic              cmd_stall;
  cmd_t              cmd;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int errors;
  int pending;
  int checked;
  int refused;
  int n_writes;
  int cycles;
  int stall_left;
  bit calm;

  // Raw capacity values per random phase; zero and values above 16 exercise clamping.
  logic [CNT_W-1:0] phase_caps [N_PHASES] = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd16, 5'd5,
                                              5'd8, 5'd0, 5'd15, 5'd31, 5'd4, 5'd16};

  circular_deque u_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  deque_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked),
    .refused  (refused)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result back-pressure: long clear stretches, mostly short stalls, a few long ones.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (calm) begin
      rsp_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          rsp_stall  <= 1'b0;
          stall_left <= $urandom_range(1, 8);
        end
        9: begin
          rsp_stall  <= 1'b1;
          stall_left <= $urandom_range(10, 30);
        end
        default: begin
          rsp_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Leaves valid high after the transfer so back-to-back commands need no extra edge.
  task automatic send_op(logic [1:0] op, logic [DATA_W-1:0] value);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid       <= 1'b1;
    cmd.operation   <= op;
    cmd.data_value  <= value;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic drain(int settle);
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
    drain(8);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_writes++;
  endtask

  initial begin
    int mode_left;
    bit filling;
    bit take_pop;
    bit take_back;
    logic [1:0] op;
    logic [DATA_W-1:0] value;

    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    calm      = 1'b0;
    mode_left = 0;
    filling   = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, capacity 16 from reset: deletes on an empty deque, extreme values
    // at both ends, draining back to empty, and a rear pointer wrapping past the top.
    send_op(OP_POP_FRONT, 32'h0000_0001);
    send_op(OP_POP_BACK, 32'h0000_0002);
    send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_op(OP_PUSH_BACK, 32'h8000_0000);
    send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(OP_PUSH_BACK, 32'h0000_0000);
    send_op(OP_POP_FRONT, 32'hFFFF_FFFF);
    send_op(OP_POP_BACK, 32'h0000_0000);
    send_op(OP_POP_FRONT, 32'h1234_5678);
    send_op(OP_POP_BACK, 32'h8765_4321);
    send_op(OP_PUSH_BACK, 32'hA5A5_5A5A);
    // A write beyond the register list must leave the deque untouched.
    write_reg(SPARE_ADDR, 32'h0000_0003);
    send_op(OP_POP_FRONT, 32'h0);
    // Capacity zero behaves as one: a single entry fills the deque.
    write_reg(CAP_ADDR, 32'h0000_0000);
    send_op(OP_PUSH_FRONT, 32'h1234_5678);
    send_op(OP_PUSH_BACK, 32'h5555_5555);
    send_op(OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send_op(OP_POP_BACK, 32'h0);
    send_op(OP_POP_FRONT, 32'h0);
    // Oversized capacity with junk in the upper bits clamps to 16.
    write_reg(CAP_ADDR, 32'hFFFF_FFFF);
    send_op(OP_PUSH_FRONT, 32'h0F0F_0F0F);
    send_op(OP_PUSH_FRONT, 32'hF0F0_F0F0);
    // A capacity write with entries present empties the deque.
    write_reg(CAP_ADDR, 32'h0000_0002);
    send_op(OP_POP_FRONT, 32'h0);
    send_op(OP_PUSH_BACK, 32'h0000_0011);
    send_op(OP_PUSH_BACK, 32'h0000_0022);
    send_op(OP_PUSH_FRONT, 32'h0000_0033);
    send_op(OP_POP_BACK, 32'h0);
    send_op(OP_POP_FRONT, 32'h0);

    // Random part: alternate fill-heavy and drain-heavy runs so each capacity is
    // driven to full and empty many times with both pointers wrapping.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(CAP_ADDR, {27'($urandom >> 5), phase_caps[ph]});
      calm = (ph % 4 == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (mode_left == 0) begin
          filling   = $urandom_range(0, 1);
          mode_left = $urandom_range(2, 40);
        end
        mode_left--;
        take_pop  = ($urandom_range(0, 9) < 8) ? !filling : filling;
        take_back = $urandom_range(0, 1);
        if (take_pop) begin
          op = take_back ? OP_POP_BACK : OP_POP_FRONT;
        end else begin
          op = take_back ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       value = 32'h7FFF_FFFF;
            1:       value = 32'h8000_0000;
            2:       value = '1;
            default: value = '0;
          endcase
        end else begin
          value = $urandom;
        end
        send_op(op, value);
      end
    end

    calm = 1'b0;
    drain(16);
    $display("Checked %0d deque operations, %0d of them refused on a full or empty deque,",
             checked, refused);
    $display("over %0d register writes covering capacities 1 to 16 and out-of-range values.",
             n_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cdq_pkg.sv
hdl/cdq_ram.sv
hdl/cdq_ctrl.sv
hdl/cdq_dpath.sv
hdl/circular_deque.sv
verif/deque_checker.sv
verif/tb.sv
